// ===== design/mwm_pkg.sv =====
// shared types and constants for the maze wall map store
package mwm_pkg;

	// request field widths
	localparam int COORD_W = 5;
	localparam int WALL_W  = 4;
	localparam int CELL_W  = 8;

	// operation codes
	localparam logic FUNC_READ   = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// one stored wall entry: bit0 present, bit1 known
	localparam int ENTRY_W     = 2;
	localparam int PRESENT_BIT = 0;
	localparam int KNOWN_BIT   = 1;

	typedef logic [ENTRY_W-1:0] wall_entry_t;

	// outer boundary reads as present and known
	localparam wall_entry_t ENTRY_BOUNDARY = 2'b11;

	// wall order in seen_walls and in each half of cell_walls
	localparam int SIDE_N = 0;
	localparam int SIDE_E = 1;
	localparam int SIDE_S = 2;
	localparam int SIDE_W = 3;

	// known flags start at this bit of cell_walls
	localparam int KNOWN_OFS = 4;

endpackage

// ===== design/maze_wall_map_store.sv =====
// top level of the maze wall map store: request register, wall stores, result register
//
//  channel   direction  handshake            fields
//  request   in         start && !busy       func, col, row, seen_walls, force_req
//  result    out        done (one cycle)     cell_walls, written
//
// one request can be taken every cycle; busy is held low
// done and the result are registered: the store words are read on the request edge,
//   and lookup and merge fill the result register on the next edge
// reset clears the per-word valid bits at once, so no clearing pass is needed
// the receiver cannot stall: each result is shown for exactly one cycle
// a write and a read of the same word on one edge are resolved by forwarding
module maze_wall_map_store #(
	parameter int GRID_SIZE = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            func,
	input  logic [mwm_pkg::COORD_W-1:0]     col,
	input  logic [mwm_pkg::COORD_W-1:0]     row,
	input  logic [mwm_pkg::WALL_W-1:0]      seen_walls,
	input  logic                            force_req,
	output logic                            done,
	output logic [mwm_pkg::CELL_W-1:0]      cell_walls,
	output logic                            written
);
	import mwm_pkg::*;

	localparam int IW = $clog2(GRID_SIZE);
	localparam int XW = ((IW > COORD_W) ? IW : COORD_W) + 1;
	localparam logic [XW-1:0] GRID_X = XW'(GRID_SIZE);

	// request side
	logic                   accept;
	logic [XW-1:0]          col_x;
	logic [XW-1:0]          row_x;
	logic                   col_ok;
	logic                   row_ok;

	// stage 1: registered request, store words arrive here
	logic                   vld_s1;
	logic                   func_s1;
	logic [COORD_W-1:0]     col_s1;
	logic [COORD_W-1:0]     row_s1;
	logic [WALL_W-1:0]      seen_s1;
	logic                   force_s1;
	logic [XW-1:0]          col_x_s1;
	logic [XW-1:0]          row_x_s1;

	// north walls are kept one word per column, east walls one word per row,
	// so a cell touches one word of each store
	wall_entry_t [GRID_SIZE-1:0] north_word;
	wall_entry_t [GRID_SIZE-1:0] east_word;
	wall_entry_t [GRID_SIZE-1:0] north_wr_word;
	wall_entry_t [GRID_SIZE-1:0] east_wr_word;
	logic                   north_wr_req;
	logic                   east_wr_req;

	// result logic
	logic [CELL_W-1:0]      walls_c;
	logic                   written_c;

	// result register
	logic                   done_q;
	logic [CELL_W-1:0]      cell_walls_q;
	logic                   written_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign col_x  = XW'(col);
	assign row_x  = XW'(row);
	assign col_ok = col_x < GRID_X;
	assign row_ok = row_x < GRID_X;

	assign col_x_s1 = XW'(col_s1);
	assign row_x_s1 = XW'(row_s1);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			col_s1   <= col;
			row_s1   <= row;
			seen_s1  <= seen_walls;
			force_s1 <= force_req;
		end
	end

	// north store, word chosen by column
	mwm_wall_bank #(
		.GRID_SIZE (GRID_SIZE)
	) u_north (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && col_ok),
		.rd_addr (col_x[IW-1:0]),
		.rd_word (north_word),
		.wr_en   (north_wr_req),
		.wr_addr (col_x_s1[IW-1:0]),
		.wr_data (north_wr_word)
	);

	// east store, word chosen by row
	mwm_wall_bank #(
		.GRID_SIZE (GRID_SIZE)
	) u_east (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && row_ok),
		.rd_addr (row_x[IW-1:0]),
		.rd_word (east_word),
		.wr_en   (east_wr_req),
		.wr_addr (row_x_s1[IW-1:0]),
		.wr_data (east_wr_word)
	);

	// wall lookup and update merge
	logic north_wr_c;
	logic east_wr_c;

	mwm_cell_logic #(
		.GRID_SIZE (GRID_SIZE)
	) u_cell (
		.func          (func_s1),
		.col           (col_s1),
		.row           (row_s1),
		.seen_walls    (seen_s1),
		.force_req     (force_s1),
		.north_word    (north_word),
		.east_word     (east_word),
		.cell_walls    (walls_c),
		.written       (written_c),
		.north_wr_en   (north_wr_c),
		.north_wr_word (north_wr_word),
		.east_wr_en    (east_wr_c),
		.east_wr_word  (east_wr_word)
	);

	// only a live request may touch the stores
	assign north_wr_req = vld_s1 && north_wr_c;
	assign east_wr_req  = vld_s1 && east_wr_c;

	// result register, one strobe per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			cell_walls_q <= walls_c;
			written_q    <= written_c;
		end
	end

	assign done       = done_q;
	assign cell_walls = cell_walls_q;
	assign written    = written_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("request produced no result strobe");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (func_s1 == FUNC_READ)) |-> (!north_wr_req && !east_wr_req))
		else $error("read request modified the wall map");

	a_written_update: assert property (@(posedge clk) disable iff (!arst_n)
		(done && written) |-> $past(vld_s1 && (func_s1 == FUNC_UPDATE)))
		else $error("written flag without an update request");

endmodule

// ===== design/mwm_wall_bank.sv =====
// one wall store: line-wide words with per-word valid bits and write-to-read bypass
module mwm_wall_bank #(
	parameter int GRID_SIZE = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            rd_en,
	input  logic [$clog2(GRID_SIZE)-1:0]                    rd_addr,
	output mwm_pkg::wall_entry_t [GRID_SIZE-1:0]            rd_word,
	input  logic                                            wr_en,
	input  logic [$clog2(GRID_SIZE)-1:0]                    wr_addr,
	input  mwm_pkg::wall_entry_t [GRID_SIZE-1:0]            wr_data
);
	import mwm_pkg::*;

	typedef wall_entry_t [GRID_SIZE-1:0] line_word_t;

	line_word_t             mem [GRID_SIZE];
	logic [GRID_SIZE-1:0]   valid_q;
	line_word_t             raw_s1;
	line_word_t             byp_data_s1;
	logic                   byp_s1;
	logic                   vld_s1;

	// word storage, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_s1 <= mem[rd_addr];
		end
	end

	// a word never written reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// same-edge write to the word being read is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_s1 <= 1'b0;
			vld_s1 <= 1'b0;
		end else if (rd_en) begin
			byp_s1 <= wr_en && (wr_addr == rd_addr);
			vld_s1 <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_data_s1 <= wr_data;
		end
	end

	assign rd_word = byp_s1 ? byp_data_s1 : (vld_s1 ? raw_s1 : '0);

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (int'(wr_addr) < GRID_SIZE))
		else $error("wall bank write beyond the grid");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (int'(rd_addr) < GRID_SIZE))
		else $error("wall bank read beyond the grid");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en && (wr_addr == rd_addr)) |=> (rd_word == $past(wr_data)))
		else $error("wall bank bypass lost a same-cycle write");

endmodule

// ===== design/mwm_cell_logic.sv =====
// wall lookup, boundary handling and update merge for one cell
module mwm_cell_logic #(
	parameter int GRID_SIZE = 32
) (
	input  logic                                    func,
	input  logic [mwm_pkg::COORD_W-1:0]             col,
	input  logic [mwm_pkg::COORD_W-1:0]             row,
	input  logic [mwm_pkg::WALL_W-1:0]              seen_walls,
	input  logic                                    force_req,
	input  mwm_pkg::wall_entry_t [GRID_SIZE-1:0]    north_word,
	input  mwm_pkg::wall_entry_t [GRID_SIZE-1:0]    east_word,
	output logic [mwm_pkg::CELL_W-1:0]              cell_walls,
	output logic                                    written,
	output logic                                    north_wr_en,
	output mwm_pkg::wall_entry_t [GRID_SIZE-1:0]    north_wr_word,
	output logic                                    east_wr_en,
	output mwm_pkg::wall_entry_t [GRID_SIZE-1:0]    east_wr_word
);
	import mwm_pkg::*;

	localparam int IW = $clog2(GRID_SIZE);
	localparam int XW = ((IW > COORD_W) ? IW : COORD_W) + 1;
	localparam logic [XW-1:0] GRID_X = XW'(GRID_SIZE);

	logic [XW-1:0]       col_x;
	logic [XW-1:0]       row_x;
	logic [IW-1:0]       ci;
	logic [IW-1:0]       ri;
	logic [IW-1:0]       ci_m1;
	logic [IW-1:0]       ri_m1;
	logic                in_grid;
	logic                n_ok;
	logic                e_ok;
	logic                s_ok;
	logic                w_ok;
	wall_entry_t         n_ent;
	wall_entry_t         e_ent;
	wall_entry_t         s_ent;
	wall_entry_t         w_ent;
	logic [WALL_W-1:0]   known;
	logic                do_wr;

	assign col_x = XW'(col);
	assign row_x = XW'(row);
	assign ci    = col_x[IW-1:0];
	assign ri    = row_x[IW-1:0];
	assign ci_m1 = ci - 1'b1;
	assign ri_m1 = ri - 1'b1;

	// which walls are inner, stored walls
	assign in_grid = (col_x < GRID_X) && (row_x < GRID_X);
	assign n_ok    = in_grid && ((row_x + 1'b1) < GRID_X);
	assign e_ok    = in_grid && ((col_x + 1'b1) < GRID_X);
	assign s_ok    = in_grid && (row != '0);
	assign w_ok    = in_grid && (col != '0);

	assign n_ent = n_ok ? north_word[ri]    : ENTRY_BOUNDARY;
	assign s_ent = s_ok ? north_word[ri_m1] : ENTRY_BOUNDARY;
	assign e_ent = e_ok ? east_word[ci]     : ENTRY_BOUNDARY;
	assign w_ent = w_ok ? east_word[ci_m1]  : ENTRY_BOUNDARY;

	always_comb begin
		cell_walls = '0;
		cell_walls[SIDE_N] = n_ent[PRESENT_BIT];
		cell_walls[SIDE_E] = e_ent[PRESENT_BIT];
		cell_walls[SIDE_S] = s_ent[PRESENT_BIT];
		cell_walls[SIDE_W] = w_ent[PRESENT_BIT];
		cell_walls[KNOWN_OFS + SIDE_N] = n_ent[KNOWN_BIT];
		cell_walls[KNOWN_OFS + SIDE_E] = e_ent[KNOWN_BIT];
		cell_walls[KNOWN_OFS + SIDE_S] = s_ent[KNOWN_BIT];
		cell_walls[KNOWN_OFS + SIDE_W] = w_ent[KNOWN_BIT];
	end

	assign known = cell_walls[KNOWN_OFS +: WALL_W];

	// skip the update once every wall is known, unless forced
	assign do_wr   = (func == FUNC_UPDATE) && (force_req || (known != '1));
	assign written = do_wr;

	always_comb begin
		north_wr_word = north_word;
		if (n_ok) begin
			north_wr_word[ri] = {1'b1, seen_walls[SIDE_N]};
		end
		if (s_ok) begin
			north_wr_word[ri_m1] = {1'b1, seen_walls[SIDE_S]};
		end
	end

	always_comb begin
		east_wr_word = east_word;
		if (e_ok) begin
			east_wr_word[ci] = {1'b1, seen_walls[SIDE_E]};
		end
		if (w_ok) begin
			east_wr_word[ci_m1] = {1'b1, seen_walls[SIDE_W]};
		end
	end

	assign north_wr_en = do_wr && (n_ok || s_ok);
	assign east_wr_en  = do_wr && (e_ok || w_ok);

endmodule

// ===== dv/maze_wall_map_checker.sv =====
// scoreboard for the maze wall map store: predicts each request and checks its result
module maze_wall_map_checker #(
	parameter int GRID_SIZE = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        func,
	input  logic [mwm_pkg::COORD_W-1:0] col,
	input  logic [mwm_pkg::COORD_W-1:0] row,
	input  logic [mwm_pkg::WALL_W-1:0]  seen_walls,
	input  logic                        force_req,
	input  logic                        done,
	input  logic [mwm_pkg::CELL_W-1:0]  cell_walls,
	input  logic                        written,
	output int                          fail_count,
	output int                          pending
);
	import mwm_pkg::*;

	typedef struct packed {
		logic [CELL_W-1:0] walls;
		logic              written;
	} cell_result_t;

	wall_entry_t  north_map [GRID_SIZE*GRID_SIZE];
	wall_entry_t  east_map  [GRID_SIZE*GRID_SIZE];
	cell_result_t cell_result_q [$];
	cell_result_t oldest;
	int           errors;

	function automatic wall_entry_t north_of(input int c, input int r);
		if (c >= GRID_SIZE || r + 1 >= GRID_SIZE)
			return ENTRY_BOUNDARY;
		return north_map[r*GRID_SIZE + c];
	endfunction

	function automatic wall_entry_t east_of(input int c, input int r);
		if (c + 1 >= GRID_SIZE || r >= GRID_SIZE)
			return ENTRY_BOUNDARY;
		return east_map[r*GRID_SIZE + c];
	endfunction

	function automatic wall_entry_t known_entry(input logic present);
		wall_entry_t entry;
		entry = '0;
		entry[KNOWN_BIT]   = 1'b1;
		entry[PRESENT_BIT] = present;
		return entry;
	endfunction

	// view of the cell before the request, then the update if it goes ahead
	function automatic cell_result_t apply_request(input logic f, input int c, input int r,
			input logic [WALL_W-1:0] seen, input logic frc);
		wall_entry_t  side [4];
		cell_result_t res;
		side[SIDE_N] = north_of(c, r);
		side[SIDE_E] = east_of(c, r);
		side[SIDE_S] = (r == 0) ? ENTRY_BOUNDARY : north_of(c, r - 1);
		side[SIDE_W] = (c == 0) ? ENTRY_BOUNDARY : east_of(c - 1, r);
		res = '0;
		for (int k = 0; k < 4; k++) begin
			res.walls[k]             = side[k][PRESENT_BIT];
			res.walls[KNOWN_OFS + k] = side[k][KNOWN_BIT];
		end
		res.written = (f == FUNC_UPDATE) && (frc || res.walls[KNOWN_OFS +: 4] != 4'hF);
		// a cell outside the grid has only boundary walls
		if (res.written && c < GRID_SIZE && r < GRID_SIZE) begin
			if (r + 1 < GRID_SIZE)
				north_map[r*GRID_SIZE + c] = known_entry(seen[SIDE_N]);
			if (r > 0)
				north_map[(r-1)*GRID_SIZE + c] = known_entry(seen[SIDE_S]);
			if (c + 1 < GRID_SIZE)
				east_map[r*GRID_SIZE + c] = known_entry(seen[SIDE_E]);
			if (c > 0)
				east_map[r*GRID_SIZE + c - 1] = known_entry(seen[SIDE_W]);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (north_map[i]) begin
				north_map[i] = '0;
				east_map[i]  = '0;
			end
			cell_result_q.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (cell_result_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: cell_walls %h written %b",
						$time, cell_walls, written);
				end else begin
					oldest = cell_result_q.pop_front();
					if (cell_walls !== oldest.walls) begin
						errors++;
						$display("%0t: cell_walls mismatch: expected %h actual %h",
							$time, oldest.walls, cell_walls);
					end
					if (written !== oldest.written) begin
						errors++;
						$display("%0t: written mismatch: expected %b actual %b",
							$time, oldest.written, written);
					end
				end
			end
			if (start && !busy)
				cell_result_q = {cell_result_q,
					apply_request(func, col, row, seen_walls, force_req)};
		end
		pending    <= cell_result_q.size();
		fail_count <= errors;
	end

endmodule

// ===== dv/tb_maze_wall_map_store.sv =====
// testbench top for the maze wall map store: request stimulus, watchdog and verdict
module tb_maze_wall_map_store;
	import mwm_pkg::*;

	localparam int QUIET_LIMIT = 1000;	// cycles with no request and no result

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic               func       = FUNC_READ;
	logic [COORD_W-1:0] col        = '0;
	logic [COORD_W-1:0] row        = '0;
	logic [WALL_W-1:0]  seen_walls = '0;
	logic               force_req  = 1'b0;
	logic               busy;
	logic               done;
	logic [CELL_W-1:0]  cell_walls;
	logic               written;
	int                 fail_count;
	int                 pending;
	int                 quiet_cycles = 0;

	maze_wall_map_store #(.GRID_SIZE(32)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.col        (col),
		.row        (row),
		.seen_walls (seen_walls),
		.force_req  (force_req),
		.done       (done),
		.cell_walls (cell_walls),
		.written    (written)
	);

	// predicts every accepted request and compares the result strobes
	maze_wall_map_checker #(.GRID_SIZE(32)) u_wall_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.col        (col),
		.row        (row),
		.seen_walls (seen_walls),
		.force_req  (force_req),
		.done       (done),
		.cell_walls (cell_walls),
		.written    (written),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog: a long stretch with no handshake on either side means a hang
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// optional idle cycles, then one request held until it is taken
	// called at a rising edge and returns at the edge that accepted the request
	task automatic issue_request(input logic f, input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] r, input logic [WALL_W-1:0] seen,
			input logic frc, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			// idle cycle: start low, fields scrambled so the block must ignore them
			start      <= 1'b0;
			func       <= 1'($urandom);
			col        <= COORD_W'($urandom);
			row        <= COORD_W'($urandom);
			seen_walls <= WALL_W'($urandom);
			force_req  <= 1'($urandom);
			@(posedge clk);
		end
		start      <= 1'b1;
		func       <= f;
		col        <= c;
		row        <= r;
		seen_walls <= seen;
		force_req  <= frc;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// back to back, so same-cell and neighbor requests land on consecutive edges
	task automatic directed_requests();
		// fresh store: only the boundary reads as known
		issue_request(FUNC_READ,   5'd0,  5'd0,  4'h0, 1'b0, 0);
		issue_request(FUNC_READ,   5'd31, 5'd31, 4'hF, 1'b1, 0);	// read ignores seen and force
		issue_request(FUNC_READ,   5'd31, 5'd0,  4'h0, 1'b0, 0);
		issue_request(FUNC_READ,   5'd0,  5'd31, 4'h0, 1'b0, 0);
		// south-west corner: write, then skip once every wall is known, then force
		issue_request(FUNC_UPDATE, 5'd0,  5'd0,  4'hF, 1'b0, 0);
		issue_request(FUNC_READ,   5'd0,  5'd0,  4'h0, 1'b0, 0);
		issue_request(FUNC_UPDATE, 5'd0,  5'd0,  4'h0, 1'b0, 0);
		issue_request(FUNC_UPDATE, 5'd0,  5'd0,  4'h0, 1'b1, 0);
		issue_request(FUNC_READ,   5'd0,  5'd0,  4'h0, 1'b0, 0);
		// neighbors share walls with the corner cell
		issue_request(FUNC_UPDATE, 5'd1,  5'd0,  4'hF, 1'b0, 0);
		issue_request(FUNC_READ,   5'd0,  5'd0,  4'h0, 1'b0, 0);
		issue_request(FUNC_UPDATE, 5'd0,  5'd1,  4'h5, 1'b0, 0);
		issue_request(FUNC_READ,   5'd0,  5'd0,  4'h0, 1'b0, 0);
		// the other corners, where the top and east edges are boundary
		issue_request(FUNC_UPDATE, 5'd31, 5'd31, 4'hA, 1'b0, 0);
		issue_request(FUNC_UPDATE, 5'd31, 5'd0,  4'h5, 1'b0, 0);
		issue_request(FUNC_UPDATE, 5'd0,  5'd31, 4'hF, 1'b0, 0);
		issue_request(FUNC_READ,   5'd30, 5'd31, 4'h0, 1'b0, 0);
		issue_request(FUNC_READ,   5'd31, 5'd30, 4'h0, 1'b0, 0);
		// interior cell with all four walls, then its surroundings
		issue_request(FUNC_UPDATE, 5'd15, 5'd16, 4'hF, 1'b0, 0);
		issue_request(FUNC_READ,   5'd15, 5'd17, 4'h0, 1'b0, 0);
		issue_request(FUNC_UPDATE, 5'd16, 5'd16, 4'h0, 1'b0, 0);
		issue_request(FUNC_READ,   5'd15, 5'd16, 4'h0, 1'b0, 0);
		issue_request(FUNC_UPDATE, 5'd15, 5'd15, 4'h3, 1'b0, 0);
		issue_request(FUNC_READ,   5'd15, 5'd16, 4'h0, 1'b0, 0);
	endtask

	// pick the corner of a small working area, often on an edge of the maze
	function automatic logic [COORD_W-1:0] pick_base();
		case ($urandom_range(2))
			0: return 5'd0;
			1: return 5'd28;
			default: return COORD_W'($urandom_range(28));
		endcase
	endfunction

	// most requests stay in a 4x4 patch so cells fill up and updates get skipped
	// or forced; the rest roam the whole maze
	task automatic random_phase(input int count, input int idle_pct);
		logic [COORD_W-1:0] base_col;
		logic [COORD_W-1:0] base_row;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] r;
		base_col = '0;
		base_row = '0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				base_col = pick_base();
				base_row = pick_base();
			end
			if ($urandom_range(99) < 75) begin
				c = COORD_W'(base_col + $urandom_range(3));
				r = COORD_W'(base_row + $urandom_range(3));
			end else begin
				c = COORD_W'($urandom);
				r = COORD_W'($urandom);
			end
			issue_request(($urandom_range(99) < 60) ? FUNC_UPDATE : FUNC_READ, c, r,
				WALL_W'($urandom), ($urandom_range(99) < 15), idle_pct);
		end
	endtask

	initial begin
		// reset held low at the start, released on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_requests();
		random_phase(180, 27);	// light sender gaps
		random_phase(180, 74);	// heavy sender gaps
		random_phase(180, 0);	// requests every cycle
		start <= 1'b0;

		// drain: wait until no predicted result is still pending
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/mwm_pkg.sv
design/mwm_wall_bank.sv
design/mwm_cell_logic.sv
design/maze_wall_map_store.sv
dv/maze_wall_map_checker.sv
dv/tb_maze_wall_map_store.sv
